>>> rtl/core/custody_id_slot_table_unit_assert.svh
// assertion macros for the custody id slot table
`ifndef CUSTODY_ID_SLOT_TABLE_UNIT_ASSERT_SVH
`define CUSTODY_ID_SLOT_TABLE_UNIT_ASSERT_SVH

// property that must hold at every clock edge out of reset
`define CIST_ASSERT(name, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error(msg);

// consequence that must hold in the cycle after the antecedent
`define CIST_ASSERT_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/core/cist_pkg.sv
package cist_pkg;

	// table geometry
	localparam int SLOTS     = 1024;
	localparam int SLOT_W    = $clog2(SLOTS);
	localparam int ID_W      = 32;
	localparam int CFG_W     = 11;
	localparam int CNT_W     = 16;
	localparam logic [CFG_W-1:0] CFG_RESET = 11'd1024;

	// remainder unit: dividend bits retired per cycle
	localparam int DIV_BITS  = 4;
	localparam int DIV_STEPS = ID_W / DIV_BITS;
	localparam int STEP_W    = $clog2(DIV_STEPS);

	typedef enum logic [1:0] {
		ACT_ADD    = 2'd0,
		ACT_NEXT   = 2'd1,
		ACT_REMOVE = 2'd2,
		ACT_CHECK  = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		STS_SUCCESS   = 2'd0,
		STS_DUPLICATE = 2'd1,
		STS_ERROR     = 2'd2,
		STS_TIMEOUT   = 2'd3
	} status_t;

	typedef struct packed {
		action_t           action;
		logic [ID_W-1:0]   item_id;
		logic [ID_W-1:0]   storage_id;
		logic              overwrite;
	} in_item_t;

	typedef struct packed {
		status_t           status;
		logic [ID_W-1:0]   found_item_id;
		logic [ID_W-1:0]   found_storage_id;
		logic [CNT_W-1:0]  entry_count;
	} out_item_t;

	// one word of the slot memory
	typedef struct packed {
		logic              valid;
		logic [ID_W-1:0]   item_id;
		logic [ID_W-1:0]   storage_id;
	} slot_word_t;

endpackage

>>> rtl/core/custody_id_slot_table_unit.sv
// Direct-mapped custody id table: every id lands in slot (id mod slots_in_use), with
// slots_in_use clamped to 1..1024, and each slot word (valid, custody id, storage id)
// sits in one single-port-write, one-port-read synchronous memory. After reset the
// block sweeps the memory to clear the valid bits and holds in_ready low meanwhile
// (configuration writes are still taken). Each item first runs through a remainder
// unit that retires 4 id bits per cycle, then a memory read state; add, remove and
// check then finish in an exec state once the result register is free, add and
// remove writing the slot back. Next walks the slot memory at one slot per cycle
// from the oldest id and passes at most slots_in_use vacant slots before it times
// out. One item is in work at a time; the result register lets the next item be
// taken while a result waits.
module custody_id_slot_table_unit (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  cist_pkg::in_item_t           in_data,
	output logic                         out_valid,
	input  logic                         out_ready,
	output cist_pkg::out_item_t          out_data,
	input  logic                         cfg_we,
	input  logic [cist_pkg::CFG_W-1:0]   cfg_wdata
);

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_DIV,
		ST_RD,
		ST_EXEC,
		ST_WALK
	} state_t;

	state_t                          state_q;
	logic [cist_pkg::CFG_W-1:0]      cfg_q;
	logic [cist_pkg::ID_W-1:0]       oldest_q;
	logic [cist_pkg::ID_W-1:0]       newest_q;
	logic [cist_pkg::CNT_W-1:0]      count_q;
	cist_pkg::in_item_t              item_q;
	logic [cist_pkg::CFG_W-1:0]      rem_q;
	logic [cist_pkg::ID_W-1:0]       dvd_q;
	logic [cist_pkg::STEP_W-1:0]     step_q;
	logic [cist_pkg::SLOT_W-1:0]     slot_q;
	logic [cist_pkg::CFG_W-1:0]      seen_q;
	logic [cist_pkg::SLOT_W-1:0]     clr_q;
	logic                            out_valid_q;
	cist_pkg::out_item_t             out_q;

	// slot memory and its registered read data
	cist_pkg::slot_word_t            mem [cist_pkg::SLOTS];
	cist_pkg::slot_word_t            rd_q;
	logic                            mem_we;
	logic                            mem_re;
	logic [cist_pkg::SLOT_W-1:0]     mem_waddr;
	logic [cist_pkg::SLOT_W-1:0]     mem_raddr;
	cist_pkg::slot_word_t            mem_wdata;

	logic [cist_pkg::CFG_W-1:0]      div_n;
	logic [cist_pkg::CFG_W-1:0]      rem_nxt;
	logic [cist_pkg::SLOT_W:0]       slot_inc;
	logic [cist_pkg::SLOT_W-1:0]     slot_wrap;
	logic                            can_emit;
	logic                            walk_end;
	logic                            walk_hit;
	logic                            id_match;
	logic                            emit;
	cist_pkg::out_item_t             res;
	logic [cist_pkg::CNT_W-1:0]      cnt_nxt;
	logic [cist_pkg::ID_W-1:0]       newest_nxt;

	// effective divisor, clamped to 1..SLOTS
	always_comb begin
		if (cfg_q == '0) begin
			div_n = cist_pkg::CFG_W'(1);
		end else if (32'(cfg_q) > 32'(cist_pkg::SLOTS)) begin
			div_n = cist_pkg::CFG_W'(cist_pkg::SLOTS);
		end else begin
			div_n = cfg_q;
		end
	end

	// remainder unit: several restoring steps per cycle on the narrow remainder
	always_comb begin
		logic [cist_pkg::CFG_W:0] t;
		rem_nxt = rem_q;
		t = '0;
		for (int i = 0; i < cist_pkg::DIV_BITS; i++) begin
			t = {rem_nxt, dvd_q[cist_pkg::ID_W-1-i]};
			if (t >= {1'b0, div_n}) begin
				t = t - {1'b0, div_n};
			end
			rem_nxt = t[cist_pkg::CFG_W-1:0];
		end
	end

	// next slot of the walk, wrapping at the divisor and where the oldest id wraps to zero
	assign slot_inc  = {1'b0, slot_q} + 1'b1;
	assign slot_wrap = ((oldest_q == '1) || (32'(slot_inc) == 32'(div_n))) ? '0
		: slot_inc[cist_pkg::SLOT_W-1:0];

	assign can_emit  = !out_valid_q || out_ready;
	assign walk_end  = (oldest_q == newest_q) || (seen_q == div_n);
	assign walk_hit  = !walk_end && rd_q.valid;
	assign id_match  = rd_q.valid && (rd_q.item_id == item_q.item_id);

	// memory access, action decode and result forming
	always_comb begin
		mem_we     = 1'b0;
		mem_re     = 1'b0;
		mem_waddr  = slot_q;
		mem_raddr  = slot_q;
		mem_wdata  = rd_q;
		emit       = 1'b0;
		cnt_nxt    = count_q;
		newest_nxt = newest_q;
		res        = '0;
		res.status = cist_pkg::STS_SUCCESS;
		unique case (state_q)
			ST_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_q;
				mem_wdata = '0;
			end
			ST_RD: begin
				mem_re = 1'b1;
			end
			ST_EXEC: begin
				if (can_emit) begin
					emit = 1'b1;
					case (item_q.action)
						cist_pkg::ACT_ADD: begin
							if (!item_q.overwrite && id_match) begin
								res.status = cist_pkg::STS_DUPLICATE;
							end else begin
								mem_we     = 1'b1;
								mem_wdata  = {1'b1, item_q.item_id, item_q.storage_id};
								if (count_q != '1) begin
									cnt_nxt = count_q + 1'b1;
								end
								if (!item_q.overwrite) begin
									newest_nxt = item_q.item_id + 1'b1;
								end
							end
						end
						cist_pkg::ACT_REMOVE: begin
							if (id_match) begin
								res.found_item_id    = rd_q.item_id;
								res.found_storage_id = rd_q.storage_id;
								mem_we               = 1'b1;
								mem_wdata.valid      = 1'b0;
								if (count_q != '0) begin
									cnt_nxt = count_q - 1'b1;
								end
							end else begin
								res.status = cist_pkg::STS_ERROR;
							end
						end
						cist_pkg::ACT_CHECK: begin
							res.status = rd_q.valid ? cist_pkg::STS_ERROR
								: cist_pkg::STS_SUCCESS;
						end
						default: begin
							res.status = cist_pkg::STS_SUCCESS;
						end
					endcase
				end
			end
			ST_WALK: begin
				if (!walk_end && !rd_q.valid) begin
					// vacant slot: fetch the following one
					mem_re    = 1'b1;
					mem_raddr = slot_wrap;
				end else if (can_emit) begin
					emit = 1'b1;
					if (walk_hit) begin
						res.found_item_id    = rd_q.item_id;
						res.found_storage_id = rd_q.storage_id;
					end else begin
						res.status = cist_pkg::STS_TIMEOUT;
					end
				end
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
		res.entry_count = cnt_nxt;
	end

	// slot memory write port
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
	end

	// slot memory read port
	always_ff @(posedge clk) begin
		if (mem_re) begin
			rd_q <= mem[mem_raddr];
		end
	end

	// sequencer, window registers and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			cfg_q       <= cist_pkg::CFG_RESET;
			oldest_q    <= '0;
			newest_q    <= '0;
			count_q     <= '0;
			step_q      <= '0;
			item_q      <= '0;
			dvd_q       <= '0;
			rem_q       <= '0;
			slot_q      <= '0;
			seen_q      <= '0;
			out_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				cfg_q <= cfg_wdata;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
				out_q       <= res;
				count_q     <= cnt_nxt;
				newest_q    <= newest_nxt;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == cist_pkg::SLOT_W'(cist_pkg::SLOTS - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (in_valid) begin
						item_q  <= in_data;
						dvd_q   <= (in_data.action == cist_pkg::ACT_NEXT) ? oldest_q
							: in_data.item_id;
						rem_q   <= '0;
						step_q  <= '0;
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					rem_q  <= rem_nxt;
					dvd_q  <= dvd_q << cist_pkg::DIV_BITS;
					step_q <= step_q + 1'b1;
					slot_q <= rem_nxt[cist_pkg::SLOT_W-1:0];
					seen_q <= '0;
					if (step_q == cist_pkg::STEP_W'(cist_pkg::DIV_STEPS - 1)) begin
						state_q <= ST_RD;
					end
				end
				ST_RD: begin
					state_q <= (item_q.action == cist_pkg::ACT_NEXT) ? ST_WALK : ST_EXEC;
				end
				ST_EXEC: begin
					if (emit) begin
						state_q <= ST_IDLE;
					end
				end
				ST_WALK: begin
					if (!walk_end && !rd_q.valid) begin
						oldest_q <= oldest_q + 1'b1;
						seen_q   <= seen_q + 1'b1;
						slot_q   <= slot_wrap;
					end else if (emit) begin
						if (!walk_hit) begin
							oldest_q <= newest_q;
						end
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	`include "custody_id_slot_table_unit_assert.svh"

	// a transfer always starts the remainder unit
	`CIST_ASSERT_NEXT(a_accept_starts_div, in_valid && in_ready, state_q == ST_DIV, "div skipped")
	// the walk never passes more slots than the divisor
	`CIST_ASSERT(a_walk_bound, (state_q != ST_WALK) || (seen_q <= div_n), "walk passed divisor")
	// no memory write while waiting or dividing
	`CIST_ASSERT(a_no_stray_write, !((state_q == ST_IDLE || state_q == ST_DIV) && mem_we), "bad write")
	// a new result only comes from a finishing action
	`CIST_ASSERT(a_emit_source, !emit || state_q == ST_EXEC || state_q == ST_WALK, "bad source")

endmodule

>>> test/custody_id_slot_table_unit_tb.sv
`timescale 1ns / 1ps

module custody_id_slot_table_unit_tb;

	// sender and receiver idling modes
	localparam int MODE_FLOW = 0;
	localparam int MODE_SEND_IDLE = 1;
	localparam int MODE_RECV_STALL = 2;
	localparam int MODE_BOTH = 3;

	localparam int unsigned LONG_HOLD = 300;
	localparam int unsigned CYCLE_LIMIT = 8_000_000;
	localparam int unsigned BULK_ADDS = 60;

	logic                         clk = 1'b0;
	logic                         arst_n = 1'b0;
	logic                         in_valid = 1'b0;
	logic                         in_ready;
	cist_pkg::in_item_t           in_data = '0;
	logic                         out_valid;
	logic                         out_ready = 1'b0;
	cist_pkg::out_item_t          out_data;
	logic                         cfg_we = 1'b0;
	logic [cist_pkg::CFG_W-1:0]   cfg_wdata = '0;

	// shadow of the slot table
	bit                           tbl_valid [cist_pkg::SLOTS];
	bit [cist_pkg::ID_W-1:0]      tbl_item [cist_pkg::SLOTS];
	bit [cist_pkg::ID_W-1:0]      tbl_store [cist_pkg::SLOTS];
	bit [cist_pkg::ID_W-1:0]      oldest_seq = '0;
	bit [cist_pkg::ID_W-1:0]      newest_seq = '0;
	bit [cist_pkg::CNT_W-1:0]     entry_total = '0;
	logic [cist_pkg::CFG_W-1:0]   span_cfg = cist_pkg::CFG_RESET;

	cist_pkg::in_item_t           pending_items [$];
	cist_pkg::out_item_t          expected_results [$];
	logic [cist_pkg::ID_W-1:0]    recent_adds [$];

	int                 idle_mode = MODE_FLOW;
	int unsigned        items_queued = 0;
	int unsigned        results_seen = 0;
	int unsigned        fail_count = 0;
	int unsigned        cycle_count = 0;
	int unsigned        hold_reqs = 0;
	int unsigned        hold_done = 0;
	int unsigned        hold_left = 0;
	bit                 in_taken = 1'b0;

	custody_id_slot_table_unit u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	// clock
	always #5 clk = ~clk;

	// apply one transfer to the shadow table and return the result it should give
	function automatic cist_pkg::out_item_t apply_to_table(cist_pkg::in_item_t it);
		cist_pkg::out_item_t r;
		int unsigned n;
		int unsigned s;
		int unsigned seen;
		bit          hit;
		n = (span_cfg == '0) ? 1
			: ((span_cfg > cist_pkg::SLOTS) ? cist_pkg::SLOTS : int'(span_cfg));
		r.status = cist_pkg::STS_SUCCESS;
		r.found_item_id = '0;
		r.found_storage_id = '0;
		s = it.item_id % n;
		case (it.action)
			cist_pkg::ACT_ADD: begin
				if (!it.overwrite && tbl_valid[s] && tbl_item[s] == it.item_id) begin
					r.status = cist_pkg::STS_DUPLICATE;
				end else begin
					tbl_valid[s] = 1'b1;
					tbl_item[s] = it.item_id;
					tbl_store[s] = it.storage_id;
					if (entry_total != '1)
						entry_total++;
					if (!it.overwrite)
						newest_seq = it.item_id + 32'd1;
				end
			end
			cist_pkg::ACT_NEXT: begin
				// walk oldest forward over vacant slots, at most one full lap
				seen = 0;
				hit = 1'b0;
				while (!hit && oldest_seq != newest_seq && seen < n) begin
					s = oldest_seq % n;
					if (tbl_valid[s]) begin
						r.found_item_id = tbl_item[s];
						r.found_storage_id = tbl_store[s];
						hit = 1'b1;
					end else begin
						oldest_seq++;
						seen++;
					end
				end
				if (!hit) begin
					oldest_seq = newest_seq;
					r.status = cist_pkg::STS_TIMEOUT;
				end
			end
			cist_pkg::ACT_REMOVE: begin
				if (tbl_valid[s] && tbl_item[s] == it.item_id) begin
					r.found_item_id = tbl_item[s];
					r.found_storage_id = tbl_store[s];
					tbl_valid[s] = 1'b0;
					if (entry_total != '0)
						entry_total--;
				end else begin
					r.status = cist_pkg::STS_ERROR;
				end
			end
			default: begin
				r.status = tbl_valid[s] ? cist_pkg::STS_ERROR : cist_pkg::STS_SUCCESS;
			end
		endcase
		r.entry_count = entry_total;
		return r;
	endfunction

	function automatic bit draw_idle(int pct);
		return pct != 0 && $urandom_range(99) < pct;
	endfunction

	task automatic check_field(input string what, input logic [cist_pkg::ID_W-1:0] want,
			input logic [cist_pkg::ID_W-1:0] got);
		if (got !== want) begin
			fail_count++;
			$display("%0t mismatch %s: expected %h, actual %h", $time, what, want, got);
		end
	endtask

	// result checking and prediction on each accepted transfer
	always @(posedge clk) begin
		cist_pkg::out_item_t want;
		cycle_count <= cycle_count + 1;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (expected_results.size() == 0) begin
					fail_count++;
					$display("%0t mismatch: expected no result, actual %h", $time, out_data);
				end else begin
					want = expected_results.pop_front();
					check_field("status", 32'(want.status), 32'(out_data.status));
					check_field("found_item_id", want.found_item_id, out_data.found_item_id);
					check_field("found_storage_id", want.found_storage_id,
						out_data.found_storage_id);
					check_field("entry_count", 32'(want.entry_count),
						32'(out_data.entry_count));
					results_seen++;
				end
			end
			in_taken = in_valid && in_ready;
			if (in_taken)
				expected_results.push_back(apply_to_table(in_data));
		end
	end

	// input driver
	always @(negedge clk) begin
		int send_pct;
		send_pct = (idle_mode == MODE_SEND_IDLE) ? 76 : ((idle_mode == MODE_BOTH) ? 16 : 0);
		if (!in_valid || in_taken) begin
			if (pending_items.size() != 0 && !draw_idle(send_pct)) begin
				in_data <= pending_items.pop_front();
				in_valid <= 1'b1;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// output ready, with long hold-off on request
	always @(negedge clk) begin
		int recv_pct;
		recv_pct = (idle_mode == MODE_RECV_STALL) ? 76 : ((idle_mode == MODE_BOTH) ? 16 : 0);
		if (hold_done != hold_reqs) begin
			hold_done <= hold_done + 1;
			hold_left <= LONG_HOLD;
			out_ready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= !draw_idle(recv_pct);
		end
	end

	task automatic write_span(input logic [cist_pkg::CFG_W-1:0] value);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		span_cfg = value;
	endtask

	task automatic push_item(input cist_pkg::action_t act, input logic [cist_pkg::ID_W-1:0] id,
			input logic [cist_pkg::ID_W-1:0] sid, input logic ovw);
		cist_pkg::in_item_t it;
		it.action = act;
		it.item_id = id;
		it.storage_id = sid;
		it.overwrite = ovw;
		pending_items.push_back(it);
		items_queued++;
	endtask

	task automatic wait_drained();
		while (results_seen != items_queued)
			@(negedge clk);
	endtask

	// mostly ids in a window just above base so adds, removes and walks interact
	task automatic queue_random(input int unsigned count, input int unsigned span,
			input logic [cist_pkg::ID_W-1:0] base, input int unsigned next_pct);
		cist_pkg::in_item_t it;
		int unsigned        pick;
		for (int unsigned k = 0; k < count; k++) begin
			it.storage_id = $urandom();
			it.overwrite = ($urandom_range(99) < 20);
			it.item_id = base + $urandom_range(2 * span + 3);
			pick = $urandom_range(99);
			if (pick < 10) begin
				it.action = cist_pkg::action_t'($urandom_range(3));
				it.item_id = $urandom();
			end else if (pick < 10 + next_pct) begin
				it.action = cist_pkg::ACT_NEXT;
			end else if (pick < 55) begin
				it.action = cist_pkg::ACT_ADD;
				recent_adds.push_back(it.item_id);
				if (recent_adds.size() > 16)
					void'(recent_adds.pop_front());
			end else if (pick < 80) begin
				it.action = cist_pkg::ACT_REMOVE;
				if (recent_adds.size() != 0 && $urandom_range(3) != 0)
					it.item_id = recent_adds[$urandom_range(recent_adds.size() - 1)];
			end else begin
				it.action = cist_pkg::ACT_CHECK;
			end
			pending_items.push_back(it);
			items_queued++;
		end
	endtask

	task automatic run_phase(input logic [cist_pkg::CFG_W-1:0] value, input int mode,
			input int unsigned count, input logic [cist_pkg::ID_W-1:0] base,
			input int unsigned next_pct);
		int unsigned n;
		write_span(value);
		n = (value == '0) ? 1 : ((value > cist_pkg::SLOTS) ? cist_pkg::SLOTS : int'(value));
		@(posedge clk);
		idle_mode = mode;
		queue_random(count, n, base, next_pct);
		wait_drained();
	endtask

	// stimulus sequence
	initial begin
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed: duplicates, overwrite, replacement, window walks and id wrap
		write_span(11'd1024);
		@(posedge clk);
		push_item(cist_pkg::ACT_CHECK, 32'd0, 32'd0, 1'b0);
		push_item(cist_pkg::ACT_NEXT, 32'd0, 32'd0, 1'b0);
		push_item(cist_pkg::ACT_REMOVE, 32'd5, 32'd0, 1'b0);
		push_item(cist_pkg::ACT_ADD, 32'd0, 32'hFFFF_FFFF, 1'b0);
		push_item(cist_pkg::ACT_ADD, 32'd0, 32'h0000_1234, 1'b0);
		push_item(cist_pkg::ACT_ADD, 32'd0, 32'd0, 1'b1);
		push_item(cist_pkg::ACT_ADD, 32'd1024, 32'hA5A5_A5A5, 1'b0);
		push_item(cist_pkg::ACT_CHECK, 32'd0, 32'd0, 1'b0);
		push_item(cist_pkg::ACT_REMOVE, 32'd0, 32'd0, 1'b0);
		push_item(cist_pkg::ACT_NEXT, 32'd0, 32'd0, 1'b0);
		push_item(cist_pkg::ACT_REMOVE, 32'd1024, 32'd0, 1'b0);
		push_item(cist_pkg::ACT_ADD, 32'hFFFF_FFFF, 32'h5A5A_5A5A, 1'b0);
		push_item(cist_pkg::ACT_NEXT, 32'd0, 32'd0, 1'b0);
		push_item(cist_pkg::ACT_ADD, 32'hFFFF_FFF0, 32'h0F0F_0F0F, 1'b0);
		push_item(cist_pkg::ACT_ADD, 32'h0000_0042, 32'hF0F0_F0F0, 1'b1);
		push_item(cist_pkg::ACT_NEXT, 32'd0, 32'd0, 1'b0);
		push_item(cist_pkg::ACT_REMOVE, 32'hFFFF_FFF0, 32'd0, 1'b0);
		push_item(cist_pkg::ACT_REMOVE, 32'h0000_0042, 32'd0, 1'b0);
		push_item(cist_pkg::ACT_NEXT, 32'd0, 32'd0, 1'b0);
		push_item(cist_pkg::ACT_REMOVE, 32'hFFFF_FFFF, 32'd0, 1'b0);
		push_item(cist_pkg::ACT_NEXT, 32'd0, 32'd0, 1'b0);
		push_item(cist_pkg::ACT_ADD, 32'hFFFF_FFFF, 32'h1357_9BDF, 1'b0);
		push_item(cist_pkg::ACT_NEXT, 32'd0, 32'd0, 1'b0);
		push_item(cist_pkg::ACT_REMOVE, 32'hFFFF_FFFF, 32'd0, 1'b0);
		push_item(cist_pkg::ACT_NEXT, 32'd0, 32'd0, 1'b0);
		wait_drained();

		// random phases over several divisors, out-of-range ones included
		run_phase(11'd7, MODE_FLOW, 120, 32'h0000_0100, 20);
		run_phase(11'd1, MODE_SEND_IDLE, 100, 32'hFFFF_FFF8, 20);
		run_phase(11'd0, MODE_RECV_STALL, 60, 32'h7FFF_FFFE, 20);
		run_phase(11'd2047, MODE_BOTH, 120, 32'hFFFF_FC00, 6);

		// receiver holds off while the sender keeps offering
		write_span(11'd64);
		@(posedge clk);
		idle_mode = MODE_FLOW;
		queue_random(40, 64, 32'h1234_5000, 15);
		hold_reqs++;
		wait_drained();

		run_phase(11'd1025, MODE_RECV_STALL, 90, 32'h0000_0000, 6);
		run_phase(11'd100, MODE_BOTH, 120, 32'hABCD_0000, 15);

		// a run of adds into a small table, then mixed traffic
		write_span(11'd5);
		@(posedge clk);
		idle_mode = MODE_FLOW;
		for (int unsigned k = 0; k < BULK_ADDS; k++)
			push_item(cist_pkg::ACT_ADD, 32'h8000_0000 + k, $urandom(), 1'($urandom_range(1)));
		queue_random(30, 5, 32'h8000_0020, 10);
		wait_drained();

		repeat (40) @(posedge clk);
		if (fail_count == 0 && expected_results.size() == 0)
			$display("PASS custody_id_slot_table_unit");
		else
			$display("FAIL custody_id_slot_table_unit");
		$finish;
	end

	// run limit
	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("FAIL custody_id_slot_table_unit");
		$finish;
	end

endmodule

>>> filelist.f
+incdir+rtl/core
rtl/core/cist_pkg.sv
rtl/core/custody_id_slot_table_unit.sv
test/custody_id_slot_table_unit_tb.sv
